// ===== hw/rtl/gsht_pkg.sv =====
// Shared constants for the generational slot handle table.
// Depends on nothing; the interfaces, the top level and the testbench import it.
`default_nettype none

package gsht_pkg;

  localparam int SLOTS    = 64;
  localparam int GEN_BITS = 16;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ID_W  = 7;
  localparam int GEN_W = GEN_BITS;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_STALE   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/gsht_if.sv =====
// Valid/ready channel interfaces for the handle table's request and result sides.
// Depends on gsht_pkg for field widths.
`default_nettype none

interface gsht_in_if
  import gsht_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ID_W-1:0]  handle_id;
  logic [GEN_W-1:0] handle_generation;

  modport source (output valid, output opcode, output handle_id, output handle_generation,
                  input ready);
  modport sink   (input valid, input opcode, input handle_id, input handle_generation,
                  output ready);
endinterface

interface gsht_out_if
  import gsht_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  slot_id;
  logic [GEN_W-1:0] generation;
  logic             reused_slot;
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] allocated_slots;

  modport source (output valid, output status, output slot_id, output generation,
                  output reused_slot, output live_count, output allocated_slots,
                  input ready);
  modport sink   (input valid, input status, input slot_id, input generation,
                  input reused_slot, input live_count, input allocated_slots,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gsht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gsht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/generational_slot_handle_table.sv =====
// Top level of the generational slot handle table.
// Depends on gsht_pkg, gsht_if (channel interfaces) and gsht_ram (generation store).
`default_nettype none

// Generational slot handle table. Takes one request (create, destroy, look up)
// per clock while the result side is not stalled, and returns exactly one result
// per request, in order. An accepted request is registered into the check stage,
// its result into the output register; a stall at the output holds the check stage.
// Create picks the lowest inactive slot; destroy and look up check the handle
// against the slot's active bit and generation. The active bits are flip-flops
// cleared by reset; the generation RAM needs no clearing pass, since any entry
// below the high-water mark has been written and any entry at or above it reads as
// zero. Back-to-back requests that touch the same slot are handled by forwarding
// the committed state into the next request's slot search and RAM read.
module generational_slot_handle_table
  import gsht_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  gsht_in_if.sink   in_chan,
  gsht_out_if.source out_chan
);

  // Handshake
  logic in_fire;
  logic s_adv;
  logic s_fire;

  // Check stage registers
  logic             s_valid_r;
  logic [OP_W-1:0]  s_op_r;
  logic [ID_W-1:0]  s_id_r;
  logic [GEN_W-1:0] s_hgen_r;
  logic [IDX_W-1:0] s_idx_r;
  logic             s_found_r;
  logic             byp_r;
  logic [GEN_W-1:0] byp_gen_r;

  // Table state
  logic [SLOTS-1:0] act_r;
  logic [CNT_W-1:0] live_r;
  logic [CNT_W-1:0] alloc_r;

  // Result register
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [ID_W-1:0]  out_id_r;
  logic [GEN_W-1:0] out_gen_r;
  logic             out_reused_r;
  logic [CNT_W-1:0] out_live_r;
  logic [CNT_W-1:0] out_alloc_r;

  // Check stage logic
  logic [GEN_W-1:0] ram_rdata;
  logic [GEN_W-1:0] gen_cur;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_new;
  logic             upd_gen;
  logic [ST_W-1:0]  res_status;
  logic [ID_W-1:0]  res_id;
  logic [GEN_W-1:0] res_gen;
  logic             res_reused;
  logic [SLOTS-1:0] act_nxt;
  logic [CNT_W-1:0] live_nxt;
  logic [CNT_W-1:0] alloc_nxt;

  // Accept-side logic
  logic [SLOTS-1:0] act_post;
  logic             ff_found;
  logic [IDX_W-1:0] ff_idx;
  logic [IDX_W-1:0] acc_raddr;
  logic             byp_hit;

  // Advance the check stage whenever the result register is free or being drained.
  assign s_adv         = !out_valid_r || out_chan.ready;
  assign s_fire        = s_valid_r && s_adv;
  assign in_chan.ready = !s_valid_r || s_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Entries at or above the high-water mark were never written: read them as zero.
  // A write to the same slot on the accept cycle is forwarded instead of the RAM word.
  always_comb begin
    if (byp_r) begin
      gen_cur = byp_gen_r;
    end else if (CNT_W'(s_idx_r) < alloc_r) begin
      gen_cur = ram_rdata;
    end else begin
      gen_cur = '0;
    end
  end

  // New generation on create: bump and skip zero on wrap.
  assign gen_inc = gen_cur + GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  // Resolve the request held in the check stage.
  always_comb begin
    res_status = ST_OK;
    res_id     = s_id_r;
    res_gen    = gen_cur;
    res_reused = 1'b0;
    act_nxt    = act_r;
    live_nxt   = live_r;
    alloc_nxt  = alloc_r;
    upd_gen    = 1'b0;
    case (s_op_r)
      OP_CREATE: begin
        if (!s_found_r) begin
          res_status = ST_FULL;
          res_id     = '0;
          res_gen    = '0;
        end else begin
          res_id           = ID_W'(s_idx_r) + ID_W'(1);
          res_gen          = gen_new;
          res_reused       = CNT_W'(s_idx_r) < alloc_r;
          act_nxt[s_idx_r] = 1'b1;
          live_nxt         = live_r + CNT_W'(1);
          upd_gen          = 1'b1;
          if (!(CNT_W'(s_idx_r) < alloc_r)) begin
            alloc_nxt = CNT_W'(s_idx_r) + CNT_W'(1);
          end
        end
      end
      default: begin
        // Destroy, look up, and the unused code that behaves as look up.
        if (s_id_r == '0) begin
          res_status = ST_INVALID;
          res_id     = '0;
          res_gen    = '0;
        end else if (s_id_r > alloc_r || s_id_r > ID_W'(SLOTS)) begin
          res_status = ST_STALE;
          res_gen    = '0;
        end else if (!act_r[s_idx_r] || gen_cur != s_hgen_r) begin
          res_status = ST_STALE;
        end else if (s_op_r == OP_DESTROY) begin
          act_nxt[s_idx_r] = 1'b0;
          live_nxt         = live_r - CNT_W'(1);
        end
      end
    endcase
  end

  // Forward this cycle's commit into the next request's slot search.
  assign act_post = s_fire ? act_nxt : act_r;

  // Lowest inactive slot.
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_post[i]) begin
        ff_found = 1'b1;
        ff_idx   = IDX_W'(i);
      end
    end
  end

  // Create reads the chosen free slot; checks read the handle's slot.
  assign acc_raddr = (in_chan.opcode == OP_CREATE) ? ff_idx
                                                   : IDX_W'(in_chan.handle_id - ID_W'(1));
  assign byp_hit   = s_fire && upd_gen && (s_idx_r == acc_raddr);

  gsht_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (s_fire && upd_gen),
    .waddr (s_idx_r),
    .wdata (gen_new),
    .re    (in_fire),
    .raddr (acc_raddr),
    .rdata (ram_rdata)
  );

  // Control and table state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= '0;
      live_r      <= '0;
      alloc_r     <= '0;
    end else begin
      if (in_fire) begin
        s_valid_r <= 1'b1;
      end else if (s_fire) begin
        s_valid_r <= 1'b0;
      end
      if (s_fire) begin
        out_valid_r <= 1'b1;
        act_r       <= act_nxt;
        live_r      <= live_nxt;
        alloc_r     <= alloc_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_op_r    <= in_chan.opcode;
      s_id_r    <= in_chan.handle_id;
      s_hgen_r  <= in_chan.handle_generation;
      s_idx_r   <= acc_raddr;
      s_found_r <= ff_found;
      byp_r     <= byp_hit;
      byp_gen_r <= gen_new;
    end
    if (s_fire) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_gen_r    <= res_gen;
      out_reused_r <= res_reused;
      out_live_r   <= live_nxt;
      out_alloc_r  <= alloc_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.slot_id         = out_id_r;
  assign out_chan.generation      = out_gen_r;
  assign out_chan.reused_slot     = out_reused_r;
  assign out_chan.live_count      = out_live_r;
  assign out_chan.allocated_slots = out_alloc_r;

  // Live count tracks the active bits exactly.
  a_live_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(act_r) == 32'(live_r))
    else $error("live count differs from active bit population");

  // Live count never exceeds the high-water mark.
  a_live_below_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= alloc_r)
    else $error("more live slots than allocated slots");

  // High-water mark never drops outside reset.
  a_alloc_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> alloc_r >= $past(alloc_r))
    else $error("high-water mark decreased");

  // Table full is reported only when every slot is live.
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_live_r == CNT_W'(SLOTS))
    else $error("table full reported with a free slot");

  // A successful create or check never reports generation zero.
  a_ok_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> out_gen_r != '0)
    else $error("ok result with generation zero");

endmodule

`default_nettype wire

// ===== tb/generational_slot_handle_table_tb.sv =====
// Self-checking testbench for the generational slot handle table.
// Depends on gsht_pkg, the gsht_in_if/gsht_out_if channel interfaces and the table top level; drives the
// request channel, checks every result against an in-bench table model.

module generational_slot_handle_table_tb
  import gsht_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no name in the package; the table treats it as a look up.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int SWEEP_PAIRS  = 8;       // create/check/destroy rounds on the lowest slot
  localparam int HOLD_CYCLES  = 120;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;       // idle margin after the last result
  localparam int CYCLE_LIMIT  = 2000000;

  typedef enum {TIDE_FILL, TIDE_DRAIN, TIDE_MIX} tide_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  slot_id;
    logic [GEN_W-1:0] generation;
    logic             reused_slot;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] allocated_slots;
  } table_result_t;

  // Shadow copy of the handle table plus the queue of results still owed.
  class handle_table_scoreboard_t;
    bit               busy [SLOTS];
    logic [GEN_W-1:0] gen_of [SLOTS];
    int unsigned      high_water;
    int unsigned      live;
    logic [ID_W-1:0]  last_id;
    logic [GEN_W-1:0] last_gen;
    table_result_t    owed_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      n_status [4];
    int unsigned      reuses;
    int unsigned      wraps;

    function new();
      foreach (busy[i]) begin
        busy[i]   = 1'b0;
        gen_of[i] = '0;
      end
      high_water = 0;
      live       = 0;
    endfunction

    function table_result_t apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                          logic [GEN_W-1:0] gen);
      table_result_t    r;
      int               slot;
      logic [GEN_W-1:0] next_gen;
      r    = '0;
      slot = -1;
      if (op == OP_CREATE) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!busy[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          r.status = ST_FULL;
          last_id  = '0;
          last_gen = '0;
        end else begin
          // Skip generation zero on wrap so a null-looking handle never matches.
          next_gen = gen_of[slot] + GEN_W'(1);
          if (next_gen == '0) begin
            next_gen = GEN_W'(1);
            wraps++;
          end
          r.reused_slot = (slot < high_water);
          gen_of[slot]  = next_gen;
          busy[slot]    = 1'b1;
          live++;
          if (!r.reused_slot) high_water = slot + 1;
          r.status     = ST_OK;
          r.slot_id    = ID_W'(slot + 1);
          r.generation = next_gen;
          last_id      = ID_W'(slot + 1);
          last_gen     = next_gen;
        end
      end else if (id == 0) begin
        r.status = ST_INVALID;
      end else if (id > high_water) begin
        r.status  = ST_STALE;
        r.slot_id = id;
      end else begin
        r.slot_id    = id;
        r.generation = gen_of[id-1];
        if (!busy[id-1] || gen_of[id-1] != gen) begin
          r.status = ST_STALE;
        end else begin
          r.status = ST_OK;
          if (op == OP_DESTROY) begin
            busy[id-1] = 1'b0;
            live--;
          end
        end
      end
      r.live_count      = CNT_W'(live);
      r.allocated_slots = CNT_W'(high_water);
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [GEN_W-1:0] gen);
      table_result_t r;
      r      = apply_request(op, id, gen);
      owed_q = {owed_q, r};
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with nothing owed: status %0d slot %0d", got.status,
                         got.slot_id));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      n_status[want.status]++;
      if (want.reused_slot) reuses++;
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d", checked, got.status,
                         want.status));
      if (got.slot_id !== want.slot_id)
        report($sformatf("result %0d slot_id %0d, expected %0d", checked, got.slot_id,
                         want.slot_id));
      if (got.generation !== want.generation)
        report($sformatf("result %0d generation %0h, expected %0h", checked,
                         got.generation, want.generation));
      if (got.reused_slot !== want.reused_slot)
        report($sformatf("result %0d reused_slot %0b, expected %0b", checked,
                         got.reused_slot, want.reused_slot));
      if (got.live_count !== want.live_count)
        report($sformatf("result %0d live_count %0d, expected %0d", checked,
                         got.live_count, want.live_count));
      if (got.allocated_slots !== want.allocated_slots)
        report($sformatf("result %0d allocated_slots %0d, expected %0d", checked,
                         got.allocated_slots, want.allocated_slots));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   hold_ticket = 0;
  int   cycle_count = 0;

  handle_table_scoreboard_t sb = new();

  gsht_in_if  in_if();
  gsht_out_if out_if();

  generational_slot_handle_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Kill the run if it hangs; the limit is many times the slowest legal run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results owed", cycle_count, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // Offer one request and hold it until the table takes it. Valid stays high on
  // return so back-to-back requests need no extra assignment.
  task automatic push_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [GEN_W-1:0] gen);
    in_if.valid             <= 1'b1;
    in_if.opcode            <= op;
    in_if.handle_id         <= id;
    in_if.handle_generation <= gen;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_request(op, id, gen);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pause the request side until every owed result has come back.
  task automatic wait_all_results();
    if (sb.pending() != 0) begin
      in_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end
  endtask

  // Pick a one-based id among allocated slots that are active (or inactive).
  function automatic int pick_slot(bit want_busy);
    int cands[$];
    for (int i = 0; i < sb.high_water; i++)
      if (sb.busy[i] == want_busy) cands = {cands, i + 1};
    if (cands.size() == 0) return 0;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  function automatic logic [OP_W-1:0] pick_check_op(tide_t tide);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < ((tide == TIDE_DRAIN) ? 14 : 9)) return OP_DESTROY;
    if (roll < 18) return OP_LOOKUP;
    return OP_SPARE;
  endfunction

  // Build the next random request from the current table contents: mostly
  // well-formed creates and live handles, the rest broken handles of every kind.
  task automatic next_request(input tide_t tide, output logic [OP_W-1:0] op,
                              output logic [ID_W-1:0] id, output logic [GEN_W-1:0] gen);
    int roll;
    int create_w;
    int live_w;
    int slot;
    case (tide)
      TIDE_FILL: begin
        create_w = 70;
        live_w   = 12;
      end
      TIDE_DRAIN: begin
        create_w = 12;
        live_w   = 58;
      end
      default: begin
        create_w = 35;
        live_w   = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    op   = pick_check_op(tide);
    id   = ID_W'($urandom_range(0, 127));
    gen  = GEN_W'($urandom_range(0, 65535));
    if (roll < create_w) begin
      // Handle fields are don't-care on create; leave them random.
      op = OP_CREATE;
    end else if (roll < create_w + live_w) begin
      slot = pick_slot(1'b1);
      if (slot == 0) begin
        op = OP_CREATE;
      end else begin
        id  = ID_W'(slot);
        gen = sb.gen_of[slot-1];
      end
    end else begin
      case ($urandom_range(0, 5))
        0, 1: begin
          // Wrong generation on an allocated slot (one flipped bit or a random mask), or any id on an empty table.
          if (sb.high_water == 0) begin
            id = ID_W'($urandom_range(1, 127));
          end else begin
            id  = ID_W'($urandom_range(1, sb.high_water));
            gen = sb.gen_of[id-1] ^ (($urandom_range(0, 1) == 0) ?
                  GEN_W'(1) << $urandom_range(0, GEN_W - 1) : GEN_W'($urandom_range(1, 65535)));
          end
        end
        2: begin
          // Right generation, slot already destroyed; a null id if there is no such slot.
          slot = pick_slot(1'b0);
          if (slot == 0) begin
            id = '0;
          end else begin
            id  = ID_W'(slot);
            gen = sb.gen_of[slot-1];
          end
        end
        3: id = '0;
        default: id = ID_W'($urandom_range(sb.high_water + 1, 127));
      endcase
    end
  endtask

  task automatic run_tide(input tide_t tide, input int count);
    int burst;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [GEN_W-1:0] gen;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > count) burst = count;
      repeat (burst) begin
        next_request(tide, op, id, gen);
        push_request(op, id, gen);
      end
      count -= burst;
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  // Cycle the lowest slot through create, check and destroy a few rounds.
  task automatic sweep_generation();
    if (sb.busy[0]) push_request(OP_DESTROY, ID_W'(1), sb.gen_of[0]);
    for (int n = 0; n < SWEEP_PAIRS; n++) begin
      push_request(OP_CREATE, ID_W'($urandom_range(0, 127)),
                   GEN_W'($urandom_range(0, 65535)));
      push_request(($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_SPARE, sb.last_id,
                   sb.last_gen);
      push_request(OP_DESTROY, sb.last_id, sb.last_gen);
      if ($urandom_range(0, 31) == 0) idle_sender($urandom_range(1, 3));
    end
  endtask

  // Result side: check every transfer, then pick ready for the next edge. Ready
  // follows rotating patterns (always on, random, sparse) unless a hold-off runs.
  initial begin : result_sink
    table_result_t got;
    logic [31:0]   pattern;
    int            pattern_left;
    int            hold_left;
    int            hold_seen;
    int            roll;
    pattern      = '1;
    pattern_left = 0;
    hold_left    = 0;
    hold_seen    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.status          = out_if.status;
        got.slot_id         = out_if.slot_id;
        got.generation      = out_if.generation;
        got.reused_slot     = out_if.reused_slot;
        got.live_count      = out_if.live_count;
        got.allocated_slots = out_if.allocated_slots;
        sb.check_result(got);
      end
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          roll = $urandom_range(0, 9);
          if (roll < 3)      pattern = '1;
          else if (roll < 7) pattern = $urandom;
          else               pattern = $urandom & $urandom;
          pattern_left = 32;
        end
        out_if.ready <= pattern[0];
        pattern      = {pattern[0], pattern[31:1]};
        pattern_left--;
      end
    end
  end

  initial begin : request_source
    tide_t tide;
    int    left;
    int    tide_len;
    int    tide_no;
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.opcode            <= OP_CREATE;
    in_if.handle_id         <= '0;
    in_if.handle_generation <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: null and out-of-range handles on an empty table, first use of
    // slots, stale generation, destroyed slot, spare opcode, reuse of a slot.
    push_request(OP_LOOKUP,  7'd0,   16'hFFFF);
    push_request(OP_DESTROY, 7'd0,   16'h0000);
    push_request(OP_SPARE,   7'd0,   16'hAAAA);
    push_request(OP_LOOKUP,  7'd1,   16'h0000);
    push_request(OP_DESTROY, 7'd127, 16'hFFFF);
    push_request(OP_CREATE,  7'd127, 16'hFFFF);
    push_request(OP_CREATE,  7'd0,   16'h0000);
    idle_sender(2);
    push_request(OP_LOOKUP,  7'd1,   16'h0001);
    push_request(OP_LOOKUP,  7'd1,   16'h0002);
    push_request(OP_DESTROY, 7'd1,   16'h8001);
    push_request(OP_DESTROY, 7'd2,   16'h0001);
    push_request(OP_DESTROY, 7'd2,   16'h0001);
    push_request(OP_LOOKUP,  7'd2,   16'h0001);
    push_request(OP_SPARE,   7'd1,   16'h0001);
    idle_sender(1);
    push_request(OP_CREATE,  7'd5,   16'h5555);
    push_request(OP_CREATE,  7'd64,  16'h0001);
    push_request(OP_LOOKUP,  7'd3,   16'h0001);
    push_request(OP_LOOKUP,  7'd4,   16'h0001);
    push_request(OP_LOOKUP,  7'd65,  16'h0001);
    push_request(OP_DESTROY, 7'd64,  16'h0000);
    push_request(OP_DESTROY, 7'd1,   16'h0001);
    push_request(OP_CREATE,  7'd0,   16'h0000);
    wait_all_results();

    // Random tides: fill phases favour creates to run the table into full, drain phases favour destroys.
    // Start with a long fill under a receiver hold-off so the input stalls.
    left    = RANDOM_ITEMS;
    tide_no = 0;
    while (left > 0) begin
      if (tide_no == 0) begin
        tide     = TIDE_FILL;
        tide_len = 200;
      end else begin
        tide     = tide_t'($urandom_range(0, 2));
        tide_len = $urandom_range(40, 160);
      end
      if (tide_no == 0 || tide_no == 6) hold_ticket <= hold_ticket + 1;
      if (tide_len > left) tide_len = left;
      run_tide(tide, tide_len);
      left -= tide_len;
      if (tide_no % 4 == 2) wait_all_results();
      tide_no++;
    end

    sweep_generation();

    // Drain: wait for every owed result, then keep the clock running idle to catch strays.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transfers: %0d ok, %0d null handle, %0d stale, %0d table full",
             sb.checked, sb.n_status[ST_OK], sb.n_status[ST_INVALID],
             sb.n_status[ST_STALE], sb.n_status[ST_FULL]);
    $display("slot reuses %0d, generation wraps %0d, mismatches %0d",
             sb.reuses, sb.wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gsht_pkg.sv
hw/rtl/gsht_if.sv
hw/rtl/gsht_ram.sv
hw/rtl/generational_slot_handle_table.sv
tb/generational_slot_handle_table_tb.sv
